// ===== hdl/pcxrle_pkg.sv =====
package pcxrle_pkg;

  localparam logic [7:0]  MARK_BITS  = 8'hC0;
  localparam logic [5:0]  COUNT_MASK = 6'h3F;
  localparam logic [15:0] BPL_RESET  = 16'd320;
  localparam logic [15:0] LT_RESET   = 16'd200;
  localparam logic [15:0] COL_MAX    = 16'hFFFF;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_TOTAL     = 2'd1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // an input transaction completes this cycle
    logic first;  // emit the first pixel of the accepted byte
    logic next;   // emit the next pixel of a pending run
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic emits;     // the byte at the input would produce at least one pixel
    logic multi;     // the byte at the input would produce more than one pixel
    logic rem_last;  // the next run pixel is the final one
  } dp_stat_t;

endpackage

// ===== hdl/pcx_rle_line_decoder_core.sv =====
// PCX run-length decoder for 8-bit single-plane images. Each input transaction
// carries one compressed byte; each output transaction carries one decoded
// pixel with its row, column and end-of-run, end-of-line and end-of-image flags.
// A literal byte leaves one pixel and a marker byte leaves none; the value byte
// of a run of n pixels is taken with its first pixel, and the input stays not
// ready while the single pixel output register emits the rest of the run at one
// pixel per cycle while out_ready is high. The input is only ready while no run
// is pending and the output register is empty or its pixel leaves in the same
// cycle, so a waiting pixel stalls the input. Configuration writes must only
// be issued while no pixel is in flight; a new bytes_per_line value applies
// immediately at the start of a line, otherwise from the next line.
module pcx_rle_line_decoder_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_pixel_value,
  output logic [15:0]                      out_pixel_row,
  output logic [15:0]                      out_pixel_column,
  output logic                             out_last_of_item,
  output logic                             out_line_end,
  output logic                             out_image_end
);
  import pcxrle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcxrle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcxrle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_data_byte     (in_data_byte),
    .cmd              (cmd),
    .stat             (stat),
    .out_pixel_value  (out_pixel_value),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column),
    .out_last_of_item (out_last_of_item),
    .out_line_end     (out_line_end),
    .out_image_end    (out_image_end)
  );

endmodule

// ===== hdl/pcxrle_ctrl.sv =====
module pcxrle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pcxrle_pkg::dp_stat_t stat,
  output pcxrle_pkg::dp_cmd_t  cmd
);
  import pcxrle_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          cmd.take = 1'b1;
          if (stat.emits) begin
            cmd.first     = 1'b1;
            out_valid_nxt = 1'b1;
            if (stat.multi) begin
              state_nxt = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          cmd.next      = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.rem_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/pcxrle_dp.sv =====
module pcxrle_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                          cfg_wdata,
  input  logic [7:0]                           in_data_byte,
  input  pcxrle_pkg::dp_cmd_t                  cmd,
  output pcxrle_pkg::dp_stat_t                 stat,
  output logic [7:0]                           out_pixel_value,
  output logic [15:0]                          out_pixel_row,
  output logic [15:0]                          out_pixel_column,
  output logic                                 out_last_of_item,
  output logic                                 out_line_end,
  output logic                                 out_image_end
);
  import pcxrle_pkg::*;

  logic [15:0] bpl_r, bpl_nxt;
  logic [15:0] lt_r, lt_nxt;
  logic        await_r, await_nxt;
  logic [5:0]  run_len_r, run_len_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [7:0]  value_r, value_nxt;
  logic        ends_r, ends_nxt;
  logic        ll_r, ll_nxt;

  logic [7:0]  pv_r, pv_nxt;
  logic [15:0] prow_r, prow_nxt;
  logic [15:0] pcol_r, pcol_nxt;
  logic        plast_r, plast_nxt;
  logic        pend_r, pend_nxt;
  logic        pimg_r, pimg_nxt;

  logic        is_marker;
  logic [5:0]  n_c;
  logic [15:0] budget;
  logic [15:0] total;
  logic        ends_c;
  logic        ll_c;
  logic        emit;
  logic        pix_last;
  logic        pix_ends;
  logic        pix_ll;

  assign is_marker = (in_data_byte & MARK_BITS) == MARK_BITS;
  assign n_c       = await_r ? run_len_r : (is_marker ? 6'd0 : 6'd1);
  assign budget    = (bpl_r == 16'd0) ? 16'd1 : bpl_r;
  assign total     = (lt_r == 16'd0) ? 16'd1 : lt_r;
  assign ends_c    = {10'd0, n_c} >= bytes_left_r;
  assign ll_c      = ({1'b0, row_r} + 17'd1) >= {1'b0, total};

  assign stat.emits    = n_c != 6'd0;
  assign stat.multi    = n_c > 6'd1;
  assign stat.rem_last = rem_r == 6'd1;

  assign emit     = cmd.first || cmd.next;
  assign pix_last = cmd.first ? (n_c == 6'd1) : (rem_r == 6'd1);
  assign pix_ends = cmd.first ? ends_c : ends_r;
  assign pix_ll   = cmd.first ? ll_c : ll_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpl_r        <= BPL_RESET;
      lt_r         <= LT_RESET;
      await_r      <= 1'b0;
      run_len_r    <= '0;
      bytes_left_r <= BPL_RESET;
      col_r        <= '0;
      row_r        <= '0;
      rem_r        <= '0;
    end else begin
      bpl_r        <= bpl_nxt;
      lt_r         <= lt_nxt;
      await_r      <= await_nxt;
      run_len_r    <= run_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      rem_r        <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    ends_r  <= ends_nxt;
    ll_r    <= ll_nxt;
    pv_r    <= pv_nxt;
    prow_r  <= prow_nxt;
    pcol_r  <= pcol_nxt;
    plast_r <= plast_nxt;
    pend_r  <= pend_nxt;
    pimg_r  <= pimg_nxt;
  end

  always_comb begin
    bpl_nxt        = bpl_r;
    lt_nxt         = lt_r;
    await_nxt      = await_r;
    run_len_nxt    = run_len_r;
    bytes_left_nxt = bytes_left_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    rem_nxt        = rem_r;
    value_nxt      = value_r;
    ends_nxt       = ends_r;
    ll_nxt         = ll_r;
    pv_nxt         = pv_r;
    prow_nxt       = prow_r;
    pcol_nxt       = pcol_r;
    plast_nxt      = plast_r;
    pend_nxt       = pend_r;
    pimg_nxt       = pimg_r;

    if (cfg_we) begin
      if (cfg_index == CFG_BYTES_PER_LINE) begin
        bpl_nxt = cfg_wdata;
        // The new budget applies at once only if the line has not started.
        if (col_r == 16'd0 && !await_r) begin
          bytes_left_nxt = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
        end
      end else if (cfg_index == CFG_LINE_TOTAL) begin
        lt_nxt = cfg_wdata;
      end
    end

    if (cmd.take) begin
      if (await_r) begin
        await_nxt   = 1'b0;
        run_len_nxt = '0;
      end else if (is_marker) begin
        await_nxt   = 1'b1;
        run_len_nxt = in_data_byte[5:0] & COUNT_MASK;
      end
    end

    if (cmd.first) begin
      value_nxt      = in_data_byte;
      ends_nxt       = ends_c;
      ll_nxt         = ll_c;
      rem_nxt        = n_c - 6'd1;
      bytes_left_nxt = ends_c ? budget : (bytes_left_r - {10'd0, n_c});
    end else if (cmd.next) begin
      rem_nxt = rem_r - 6'd1;
    end

    if (emit) begin
      pv_nxt    = cmd.first ? in_data_byte : value_r;
      prow_nxt  = row_r;
      pcol_nxt  = col_r;
      plast_nxt = pix_last;
      pend_nxt  = pix_last && pix_ends;
      pimg_nxt  = pix_last && pix_ends && pix_ll;
      if (pix_last && pix_ends) begin
        col_nxt = '0;
        row_nxt = pix_ll ? 16'd0 : (row_r + 16'd1);
      end else if (col_r != COL_MAX) begin
        col_nxt = col_r + 16'd1;
      end
    end
  end

  assign out_pixel_value  = pv_r;
  assign out_pixel_row    = prow_r;
  assign out_pixel_column = pcol_r;
  assign out_last_of_item = plast_r;
  assign out_line_end     = pend_r;
  assign out_image_end    = pimg_r;

endmodule

// ===== hdl/pcxrle_chk.sv =====
module pcxrle_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [7:0]                       in_data_byte,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [7:0]                       out_pixel_value,
  input logic [15:0]                      out_pixel_row,
  input logic [15:0]                      out_pixel_column,
  input logic                             out_last_of_item,
  input logic                             out_line_end,
  input logic                             out_image_end
);

  // A byte that is not taken stays offered with the same value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte))
    else $error("input transaction changed while stalled");

  // A pixel that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_value) && $stable(out_pixel_row)
      && $stable(out_pixel_column) && $stable(out_last_of_item)
      && $stable(out_line_end) && $stable(out_image_end))
    else $error("stalled output payload changed");

  // The image can only end where a line ends.
  a_img_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_line_end)
    else $error("image end without line end");

  // A line only ends on the final pixel of a byte.
  a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_last_of_item)
    else $error("line end inside a run");

endmodule

bind pcx_rle_line_decoder_core pcxrle_chk u_chk (.*);
